// ===== rtl/core/thbf_pkg.sv =====
// Shared types, opcodes and constants of the two-hash Bloom filter.
package thbf_pkg;

    localparam int FB_W        = 9;   // filter_bytes register width
    localparam int POS_W       = 12;  // bit position width (below 8 * 511)
    localparam int CNT_W       = 12;  // zero_count width
    localparam int HASH_W      = 64;
    localparam int HALF_W      = 32;
    localparam int DIV_STEPS   = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FB_W-1:0] FB_RESET = 9'd256;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_COUNT  = 2'd2;

    localparam logic [2:0] CLEAR_IN_NIBBLE [16] = '{
        3'd4, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1,
        3'd3, 3'd2, 3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd0
    };

    typedef struct packed {
        logic [1:0]        operation;
        logic [HASH_W-1:0] hash;
    } in_item_t;

    typedef struct packed {
        logic             present;
        logic [CNT_W-1:0] zero_count;
    } out_item_t;

    // Decoded request handed from the front end to the store engine.
    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic [FB_W-1:0]  nbytes;
    } cmd_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } fr_state_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_A_RD,
        BK_A_USE,
        BK_B_RD,
        BK_B_USE,
        BK_CNT,
        BK_CNT_END,
        BK_RESULT
    } bk_state_t;

    function automatic logic [3:0] clear_bits(input logic [7:0] b);
        logic [3:0] lo;
        logic [3:0] hi;
        lo = {1'b0, CLEAR_IN_NIBBLE[b[3:0]]};
        hi = {1'b0, CLEAR_IN_NIBBLE[b[7:4]]};
        return lo + hi;
    endfunction

endpackage

// ===== rtl/core/thbf_front.sv =====
// Front end: accepts requests and, for inserts and queries, reduces both hash halves modulo the bit count.
module thbf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          enable,
    input  logic [thbf_pkg::FB_W-1:0]     nbytes,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  thbf_pkg::in_item_t            s_item,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output thbf_pkg::cmd_t                cmd
);

    localparam int PW = thbf_pkg::POS_W;
    localparam int HW = thbf_pkg::HALF_W;

    thbf_pkg::fr_state_t state_reg, state_next;

    logic [1:0]                  op_reg, op_next;
    logic [HW-1:0]               quo_a_reg, quo_a_next;
    logic [HW-1:0]               quo_b_reg, quo_b_next;
    logic [PW-1:0]               rem_a_reg, rem_a_next;
    logic [PW-1:0]               rem_b_reg, rem_b_next;
    logic [thbf_pkg::FB_W-1:0]   n_reg, n_next;
    logic [4:0]                  step_reg, step_next;

    logic [PW-1:0] divisor;
    logic [PW:0]   sh_a;
    logic [PW:0]   sh_b;
    logic          accept;

    assign divisor = {n_reg, 3'b000};
    assign sh_a    = {rem_a_reg, quo_a_reg[HW-1]};
    assign sh_b    = {rem_b_reg, quo_b_reg[HW-1]};
    assign accept  = s_valid && s_ready;

    assign cmd.op     = op_reg;
    assign cmd.pos_a  = rem_a_reg;
    assign cmd.pos_b  = rem_b_reg;
    assign cmd.nbytes = n_reg;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        quo_a_next = quo_a_reg;
        quo_b_next = quo_b_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        cmd_valid  = 1'b0;
        unique case (state_reg)
            thbf_pkg::FR_IDLE: begin
                s_ready = enable;
                if (accept) begin
                    op_next    = s_item.operation;
                    quo_a_next = s_item.hash[HW-1:0];
                    quo_b_next = s_item.hash[2*HW-1:HW];
                    rem_a_next = '0;
                    rem_b_next = '0;
                    n_next     = nbytes;
                    step_next  = '0;
                    if (s_item.operation == thbf_pkg::OP_INSERT ||
                        s_item.operation == thbf_pkg::OP_QUERY) begin
                        state_next = thbf_pkg::FR_DIV;
                    end else begin
                        state_next = thbf_pkg::FR_PUSH;
                    end
                end
            end
            thbf_pkg::FR_DIV: begin
                // One restoring step per cycle on each half.
                quo_a_next = {quo_a_reg[HW-2:0], 1'b0};
                quo_b_next = {quo_b_reg[HW-2:0], 1'b0};
                if (sh_a >= {1'b0, divisor}) begin
                    rem_a_next = PW'(sh_a - {1'b0, divisor});
                end else begin
                    rem_a_next = sh_a[PW-1:0];
                end
                if (sh_b >= {1'b0, divisor}) begin
                    rem_b_next = PW'(sh_b - {1'b0, divisor});
                end else begin
                    rem_b_next = sh_b[PW-1:0];
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(thbf_pkg::DIV_STEPS - 1)) begin
                    state_next = thbf_pkg::FR_PUSH;
                end
            end
            thbf_pkg::FR_PUSH: begin
                cmd_valid = 1'b1;
                if (cmd_ready) begin
                    state_next = thbf_pkg::FR_IDLE;
                end
            end
            default: state_next = thbf_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= thbf_pkg::FR_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        quo_a_reg <= quo_a_next;
        quo_b_reg <= quo_b_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        n_reg     <= n_next;
    end

endmodule

// ===== rtl/core/thbf_queue.sv =====
// Small request queue between the front end and the store engine.
module thbf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  thbf_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output thbf_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = thbf_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    thbf_pkg::cmd_t entries_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/thbf_back.sv =====
// Store engine: owns the bit store, runs set, test and clear-bit count.
module thbf_back #(
    parameter int MAX_BYTES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    output logic                init_done,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  thbf_pkg::cmd_t      cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output thbf_pkg::out_item_t m_item
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = thbf_pkg::CNT_W;

    logic [7:0] mem [MAX_BYTES];
    logic [7:0] rdata_reg;

    thbf_pkg::bk_state_t state_reg, state_next;
    thbf_pkg::cmd_t      cmd_reg, cmd_next;
    thbf_pkg::out_item_t res_reg, res_next;
    thbf_pkg::out_item_t out_reg, out_next;

    logic                      hit_reg, hit_next;
    logic [thbf_pkg::FB_W-1:0] idx_reg, idx_next;
    logic                      pend_reg, pend_next;
    logic [CW-1:0]             acc_reg, acc_next;
    logic [AW-1:0]             clr_reg, clr_next;
    logic                      out_valid_reg, out_valid_next;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic          out_load;
    logic [CW-1:0] acc_sum;

    function automatic logic [AW-1:0] to_addr(input logic [thbf_pkg::FB_W-1:0] b);
        logic [AW+thbf_pkg::FB_W-1:0] w;
        w = {{AW{1'b0}}, b};
        return w[AW-1:0];
    endfunction

    assign init_done = (state_reg != thbf_pkg::BK_CLEAR);
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;
    assign acc_sum   = acc_reg + {{(CW-4){1'b0}}, thbf_pkg::clear_bits(rdata_reg)};

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        hit_next   = hit_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        clr_next   = clr_reg;
        cmd_ready  = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = to_addr(cmd_reg.pos_a[thbf_pkg::POS_W-1:3]);
        mem_wdata  = rdata_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            thbf_pkg::BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_BYTES - 1)) begin
                    state_next = thbf_pkg::BK_IDLE;
                end
            end
            thbf_pkg::BK_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next  = cmd;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    acc_next  = '0;
                    unique case (cmd.op)
                        thbf_pkg::OP_INSERT,
                        thbf_pkg::OP_QUERY: state_next = thbf_pkg::BK_A_RD;
                        thbf_pkg::OP_COUNT: state_next = thbf_pkg::BK_CNT;
                        default: begin
                            res_next   = '0;
                            state_next = thbf_pkg::BK_RESULT;
                        end
                    endcase
                end
            end
            thbf_pkg::BK_A_RD: begin
                state_next = thbf_pkg::BK_A_USE;
            end
            thbf_pkg::BK_A_USE: begin
                hit_next = rdata_reg[cmd_reg.pos_a[2:0]];
                if (cmd_reg.op == thbf_pkg::OP_INSERT) begin
                    mem_we    = 1'b1;
                    mem_wdata = rdata_reg | (8'b1 << cmd_reg.pos_a[2:0]);
                end
                state_next = thbf_pkg::BK_B_RD;
            end
            thbf_pkg::BK_B_RD: begin
                // Read after the first write so a shared byte sees both bits.
                mem_addr   = to_addr(cmd_reg.pos_b[thbf_pkg::POS_W-1:3]);
                state_next = thbf_pkg::BK_B_USE;
            end
            thbf_pkg::BK_B_USE: begin
                mem_addr = to_addr(cmd_reg.pos_b[thbf_pkg::POS_W-1:3]);
                if (cmd_reg.op == thbf_pkg::OP_INSERT) begin
                    mem_we    = 1'b1;
                    mem_wdata = rdata_reg | (8'b1 << cmd_reg.pos_b[2:0]);
                end
                res_next.present    = (cmd_reg.op == thbf_pkg::OP_QUERY) && hit_reg &&
                                      rdata_reg[cmd_reg.pos_b[2:0]];
                res_next.zero_count = '0;
                state_next          = thbf_pkg::BK_RESULT;
            end
            thbf_pkg::BK_CNT: begin
                // Issue one byte read per cycle, add the byte read last cycle.
                mem_addr  = to_addr(idx_reg);
                idx_next  = idx_reg + 9'd1;
                pend_next = 1'b1;
                if (pend_reg) begin
                    acc_next = acc_sum;
                end
                if (idx_reg == cmd_reg.nbytes - 9'd1) begin
                    state_next = thbf_pkg::BK_CNT_END;
                end
            end
            thbf_pkg::BK_CNT_END: begin
                res_next.present    = 1'b0;
                res_next.zero_count = acc_sum;
                state_next          = thbf_pkg::BK_RESULT;
            end
            thbf_pkg::BK_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = thbf_pkg::BK_IDLE;
                end
            end
            default: state_next = thbf_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_next       = res_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= thbf_pkg::BK_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        hit_reg <= hit_next;
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

endmodule

// ===== rtl/core/two_hash_bloom_filter.sv =====
// Insert/query: the front end runs a 32-step restoring modulo on both hash halves, then the
// request passes the queue to the store engine, which tests and on insert sets both bits.
// Count: the store engine reads each of the n bytes in use and sums their clear bits.
// The front end works on the next request while the store engine runs.
// Reset (synchronous, active low) clears the bit store one byte per cycle;
// no request is taken until it ends. Config writes always land.
module two_hash_bloom_filter #(
    parameter int MAX_BYTES = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [thbf_pkg::FB_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  thbf_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output thbf_pkg::out_item_t         m_item
);

    logic [thbf_pkg::FB_W-1:0] filter_bytes_reg, filter_bytes_next;
    logic [thbf_pkg::FB_W-1:0] nbytes;
    logic                      init_done;
    logic                      fq_valid, fq_ready;
    logic                      qb_valid, qb_ready;
    thbf_pkg::cmd_t            fq_cmd, qb_cmd;

    assign cfg_ready         = 1'b1;
    assign filter_bytes_next = (cfg_valid && cfg_ready) ? cfg_data : filter_bytes_reg;

    // Clamp the byte count into one through MAX_BYTES.
    always_comb begin
        if (filter_bytes_reg == '0) begin
            nbytes = thbf_pkg::FB_W'(1);
        end else if (32'(filter_bytes_reg) > 32'(MAX_BYTES)) begin
            nbytes = thbf_pkg::FB_W'(MAX_BYTES);
        end else begin
            nbytes = filter_bytes_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_bytes_reg <= thbf_pkg::FB_RESET;
        end else begin
            filter_bytes_reg <= filter_bytes_next;
        end
    end

    thbf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (init_done),
        .nbytes    (nbytes),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    thbf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    thbf_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> init_done)
        else $error("request accepted while store clear in progress");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !m_valid && !qb_ready)
        else $error("store engine active during clear");

    a_result_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.present && (m_item.zero_count != '0)))
        else $error("result carries both a hit and a count");

    a_cfg_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_valid |=> $stable(filter_bytes_reg))
        else $error("byte count changed without a write");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-hash Bloom filter: random and directed requests.
module testbench;
    import thbf_pkg::*;

    localparam int MAX_BYTES = 256;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 300;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 117;

    // Shadow copy of the bit store; predicts one answer per accepted request.
    class bloom_shadow;
        logic [7:0] filter_bits [MAX_BYTES];
        logic [FB_W-1:0] length_reg;
        out_item_t answers_due [$];
        int failures;
        int inserts;
        int queries;
        int hits;
        int counts;
        int spares;

        function new();
            foreach (filter_bits[i]) filter_bits[i] = 8'h00;
            length_reg = FB_RESET;
            failures = 0;
            inserts = 0;
            queries = 0;
            hits = 0;
            counts = 0;
            spares = 0;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        function void note_request(in_item_t req);
            int unsigned used;
            int unsigned nbits;
            int unsigned pos_lo;
            int unsigned pos_hi;
            int unsigned total;
            out_item_t ans;
            used = 32'(length_reg);
            if (used == 0) used = 1;
            if (used > MAX_BYTES) used = MAX_BYTES;
            nbits = used * 8;
            pos_lo = req.hash[31:0] % nbits;
            pos_hi = req.hash[63:32] % nbits;
            ans = '0;
            case (req.operation)
                OP_INSERT: begin
                    filter_bits[pos_lo >> 3][pos_lo[2:0]] = 1'b1;
                    filter_bits[pos_hi >> 3][pos_hi[2:0]] = 1'b1;
                    inserts++;
                end
                OP_QUERY: begin
                    ans.present = filter_bits[pos_lo >> 3][pos_lo[2:0]]
                                & filter_bits[pos_hi >> 3][pos_hi[2:0]];
                    queries++;
                    if (ans.present) hits++;
                end
                OP_COUNT: begin
                    total = 0;
                    for (int i = 0; i < used; i++) total += 8 - $countones(filter_bits[i]);
                    ans.zero_count = total[CNT_W-1:0];
                    counts++;
                end
                default: begin
                    spares++;
                end
            endcase
            answers_due.push_back(ans);
        endfunction

        function void check_answer(out_item_t got);
            out_item_t want;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got present=%0d zero_count=%0d",
                         $time, got.present, got.zero_count);
                failures++;
                return;
            end
            want = answers_due.pop_front();
            if (got.present !== want.present) begin
                $display("%0t: present expected %0d got %0d", $time, want.present, got.present);
                failures++;
            end
            if (got.zero_count !== want.zero_count) begin
                $display("%0t: zero_count expected %0d got %0d",
                         $time, want.zero_count, got.zero_count);
                failures++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [FB_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    in_item_t s_item;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;

    bloom_shadow shadow;
    logic [63:0] known_keys [$];
    int quiet = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int lengths_set = 0;

    two_hash_bloom_filter #(
        .MAX_BYTES(MAX_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, shadow.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: check what was taken at this edge, then pick the next ready.
    always @(posedge aclk) begin
        if (m_valid && m_ready) shadow.check_answer(m_item);
        if (quiet != 0 || stall_pct == 0) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [63:0] key);
        in_item_t req;
        req.operation = op;
        req.hash = key;
        if (quiet == 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.note_request(req);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_length(input logic [FB_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        shadow.length_reg = value;
        lengths_set++;
    endtask

    // Mostly inserts and queries of keys already inserted, plus random queries, counts and unused codes.
    task automatic random_request();
        int pick;
        logic [63:0] key;
        pick = $urandom_range(0, 99);
        key = {$urandom, $urandom};
        if (pick < 38) begin
            send_request(OP_INSERT, key);
            known_keys.push_back(key);
            if (known_keys.size() > 64) void'(known_keys.pop_front());
        end else if (pick < 68) begin
            if (known_keys.size() != 0)
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            send_request(OP_QUERY, key);
        end else if (pick < 83) begin
            send_request(OP_QUERY, key);
        end else if (pick < 95) begin
            send_request(OP_COUNT, key);
        end else begin
            send_request(OP_SPARE, key);
        end
    endtask

    initial begin
        logic [FB_W-1:0] phase_length;
        int mode;
        shadow = new();
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_item <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset length covers the whole store; hit both ends of it.
        send_request(OP_INSERT, 64'h0);
        send_request(OP_INSERT, '1);
        send_request(OP_QUERY, '1);
        send_request(OP_QUERY, 64'h0);
        send_request(OP_QUERY, 64'h0000_0001_0000_0000);
        send_request(OP_INSERT, 64'h8000_0000_7fff_ffff);
        send_request(OP_QUERY, 64'h8000_0000_7fff_ffff);
        send_request(OP_COUNT, 64'h0);
        send_request(OP_SPARE, '1);
        send_request(OP_SPARE, 64'h0);
        send_request(OP_COUNT, '1);
        wait_drained();

        // Zero length acts as a single byte.
        write_length(9'd0);
        send_request(OP_INSERT, 64'h0000_0005_0000_000b);
        send_request(OP_QUERY, 64'h0000_000d_0000_0003);
        send_request(OP_COUNT, 64'h0);
        send_request(OP_SPARE, {$urandom, $urandom});
        wait_drained();

        // Lengths past the store clamp to its size.
        write_length(9'h1ff);
        send_request(OP_QUERY, '1);
        send_request(OP_INSERT, 64'hffff_fffe_0000_07ff);
        send_request(OP_COUNT, 64'h0);
        wait_drained();

        write_length(9'd1);
        send_request(OP_INSERT, '1);
        send_request(OP_COUNT, 64'h0);
        send_request(OP_QUERY, {$urandom, $urandom});

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: phase_length = 9'd256;
                1: phase_length = 9'd1;
                2: phase_length = 9'd0;
                3: phase_length = 9'h1ff;
                4: phase_length = 9'd257;
                5: phase_length = 9'd2;
                PHASES - 1: phase_length = 9'd256;
                default: phase_length = FB_W'($urandom_range(1, 256));
            endcase
            mode = $urandom_range(0, 2);
            idle_pct = (mode == 0) ? 0 : (mode == 1) ? 12 : 35;
            mode = $urandom_range(0, 2);
            stall_pct = (mode == 0) ? 0 : (mode == 1) ? 12 : 35;
            if (ph == PHASES - 1) quiet = 1;
            write_length(phase_length);
            repeat (PHASE_ITEMS) random_request();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d inserts, %0d queries (%0d hits), %0d counts, %0d unused codes",
                 shadow.inserts, shadow.queries, shadow.hits, shadow.counts, shadow.spares);
        $display("over %0d length settings, from zero and one byte to past the store",
                 lengths_set);
        if (shadow.failures == 0 && shadow.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
